### sv/lfs_pkg.sv
package lfs_pkg;

  // Sensor patterns: bit 2 left, bit 1 centre, bit 0 right.
  localparam logic [2:0] PAT_NONE       = 3'b000;
  localparam logic [2:0] PAT_FAR_LEFT   = 3'b001;
  localparam logic [2:0] PAT_CENTRE     = 3'b010;
  localparam logic [2:0] PAT_NEAR_LEFT  = 3'b011;
  localparam logic [2:0] PAT_FAR_RIGHT  = 3'b100;
  localparam logic [2:0] PAT_SPLIT      = 3'b101;
  localparam logic [2:0] PAT_NEAR_RIGHT = 3'b110;
  localparam logic [2:0] PAT_ALL        = 3'b111;

  // Motor command pairs for the three base speeds (127 forward, 255 reverse, 0 stop).
  localparam logic [7:0] GO_FWD_ONE  = 8'd127;
  localparam logic [7:0] GO_FWD_TWO  = 8'd254;
  localparam logic [7:0] GO_REV_ONE  = 8'd255;
  localparam logic [7:0] GO_REV_TWO  = 8'd125;
  localparam logic [7:0] GO_STOP_ONE = 8'd0;
  localparam logic [7:0] GO_STOP_TWO = 8'd128;

  localparam logic [7:0] STEER_CLAMP   = 8'd127;
  localparam logic [7:0] STEER_BASE_HI = 8'd255;
  localparam logic [7:0] STEER_BASE_LO = 8'd127;

  localparam logic [9:0] LOST_MAX = 10'd1023;

  localparam logic signed [17:0] INTEG_MAX = 18'sd32767;
  localparam logic signed [17:0] INTEG_MIN = -18'sd32768;

  typedef enum logic [2:0] {
    ST_FOLLOWING   = 3'd0,
    ST_JUNCTION    = 3'd1,
    ST_LINE_LOST   = 3'd2,
    ST_TRAVEL_DONE = 3'd3,
    ST_IDLE        = 3'd4
  } run_status_t;

  typedef enum logic [2:0] {
    REG_GAIN_NEAR        = 3'd0,
    REG_GAIN_FAR         = 3'd1,
    REG_GAIN_INTEGRAL    = 3'd2,
    REG_LOST_LIMIT       = 3'd3,
    REG_JUNCTION_HOLDOFF = 3'd4,
    REG_TRAVEL_LIMIT     = 3'd5,
    REG_REVERSE_MODE     = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [7:0]  gain_near;
    logic [7:0]  gain_far;
    logic [7:0]  gain_integral;
    logic [9:0]  lost_limit;
    logic [15:0] junction_holdoff;
    logic [23:0] travel_limit;
    logic        reverse_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_near:        8'd40,
    gain_far:         8'd80,
    gain_integral:    8'd1,
    lost_limit:       10'd100,
    junction_holdoff: 16'd500,
    travel_limit:     24'hFFFFFF,
    reverse_mode:     1'b0
  };

  typedef struct packed {
    logic        action;
    logic [2:0]  sensor_bits;
    logic [23:0] elapsed_time;
  } item_t;

  typedef struct packed {
    logic [7:0]  motor_one;
    logic [7:0]  motor_two;
    logic [15:0] integral_sum;
    logic [9:0]  lost_count;
    logic [2:0]  previous_pattern;
    logic [2:0]  latest_nonzero;
    logic        skipping;
    run_status_t status;
  } state_t;

  localparam state_t STATE_RESET = '{
    motor_one:        GO_STOP_ONE,
    motor_two:        GO_STOP_TWO,
    integral_sum:     16'd0,
    lost_count:       10'd0,
    previous_pattern: PAT_NONE,
    latest_nonzero:   PAT_NONE,
    skipping:         1'b0,
    status:           ST_IDLE
  };

endpackage

### sv/lfs_step_logic.sv
// Next-state logic for one transaction: steering, integral update and stop checks.
module lfs_step_logic
  import lfs_pkg::*;
(
  input  cfg_t   cfg,
  input  state_t st,
  input  item_t  item,
  output state_t st_next
);

  logic                rev;
  logic [2:0]          pat;
  logic                is_steer;
  logic                steer_right;
  logic                use_far;
  logic signed [17:0]  delta;
  logic [7:0]          gain_sel;
  logic [15:0]         prod_full;
  logic [7:0]          prod_low;
  logic [7:0]          turn;
  logic [7:0]          strength;
  logic [7:0]          steer_hi;
  logic [7:0]          steer_lo;
  logic signed [17:0]  integ_wide;
  logic [15:0]         integ_sat;
  logic [7:0]          go_one;
  logic [7:0]          go_two;
  logic [7:0]          pat_one;
  logic [7:0]          pat_two;
  logic [9:0]          lost_bumped;
  logic [9:0]          lost_final;
  logic [2:0]          latest_upd;

  assign rev = cfg.reverse_mode;
  assign pat = item.sensor_bits;

  always_comb begin
    is_steer    = 1'b0;
    steer_right = 1'b0;
    use_far     = 1'b0;
    delta       = 18'sd0;
    case (pat)
      PAT_NEAR_RIGHT: begin
        is_steer    = 1'b1;
        steer_right = 1'b1;
        delta       = -18'sd1;
      end
      PAT_NEAR_LEFT: begin
        is_steer = 1'b1;
        delta    = 18'sd1;
      end
      PAT_FAR_RIGHT: begin
        is_steer    = 1'b1;
        steer_right = 1'b1;
        use_far     = 1'b1;
        delta       = -18'sd2;
      end
      PAT_FAR_LEFT: begin
        is_steer = 1'b1;
        use_far  = 1'b1;
        delta    = 18'sd2;
      end
      default: begin
      end
    endcase
  end

  // Only the low byte of the turn term survives, so the low byte of the
  // integral is all the product needs.
  assign gain_sel  = use_far ? cfg.gain_far : cfg.gain_near;
  assign prod_full = cfg.gain_integral * st.integral_sum[7:0];
  assign prod_low  = prod_full[7:0];
  assign turn      = steer_right ? (gain_sel - prod_low) : (gain_sel + prod_low);
  assign strength  = turn[7] ? STEER_CLAMP : turn;
  assign steer_hi  = STEER_BASE_HI - strength;
  assign steer_lo  = STEER_BASE_LO - strength;

  assign integ_wide = $signed({{2{st.integral_sum[15]}}, st.integral_sum}) + delta;

  always_comb begin
    if (integ_wide > INTEG_MAX) begin
      integ_sat = INTEG_MAX[15:0];
    end else if (integ_wide < INTEG_MIN) begin
      integ_sat = INTEG_MIN[15:0];
    end else begin
      integ_sat = integ_wide[15:0];
    end
  end

  assign go_one = rev ? GO_REV_ONE : GO_FWD_ONE;
  assign go_two = rev ? GO_REV_TWO : GO_FWD_TWO;

  always_comb begin
    pat_one = st.motor_one;
    pat_two = st.motor_two;
    if (pat == PAT_CENTRE || (pat == PAT_ALL && rev)) begin
      pat_one = go_one;
      pat_two = go_two;
    end else if (is_steer) begin
      pat_one = go_one;
      pat_two = go_two;
      if (steer_right == rev) begin
        pat_one = rev ? steer_hi : steer_lo;
      end else begin
        pat_two = rev ? steer_lo : steer_hi;
      end
    end
  end

  assign latest_upd  = (pat != PAT_NONE) ? pat : st.latest_nonzero;
  assign lost_bumped = ((pat == PAT_NONE || pat == PAT_SPLIT) && st.lost_count != LOST_MAX)
                       ? st.lost_count + 10'd1 : st.lost_count;
  assign lost_final  = (pat != PAT_NONE) ? 10'd0 : lost_bumped;

  always_comb begin
    st_next = st;
    if (item.action) begin
      st_next.integral_sum     = 16'd0;
      st_next.lost_count       = 10'd0;
      st_next.previous_pattern = PAT_NONE;
      st_next.latest_nonzero   = PAT_NONE;
      st_next.status           = ST_FOLLOWING;
      st_next.skipping         = ~rev;
      st_next.motor_one        = go_one;
      st_next.motor_two        = go_two;
    end else if (st.status == ST_FOLLOWING) begin
      if (rev) begin
        st_next.skipping = 1'b0;
        if (item.elapsed_time >= cfg.travel_limit) begin
          st_next.status = ST_TRAVEL_DONE;
        end else begin
          st_next.previous_pattern = pat;
          st_next.latest_nonzero   = latest_upd;
          st_next.motor_one        = pat_one;
          st_next.motor_two        = pat_two;
          if (is_steer) begin
            st_next.integral_sum = integ_sat;
          end
        end
      end else if (!(st.skipping && pat == PAT_ALL)) begin
        st_next.skipping         = 1'b0;
        st_next.previous_pattern = pat;
        st_next.latest_nonzero   = latest_upd;
        st_next.motor_one        = pat_one;
        st_next.motor_two        = pat_two;
        if (is_steer) begin
          st_next.integral_sum = integ_sat;
        end
        if (pat == PAT_ALL && st.previous_pattern == PAT_ALL &&
            item.elapsed_time > {8'd0, cfg.junction_holdoff}) begin
          st_next.motor_one  = GO_STOP_ONE;
          st_next.motor_two  = GO_STOP_TWO;
          st_next.status     = ST_JUNCTION;
          st_next.lost_count = lost_bumped;
        end else begin
          st_next.lost_count = lost_final;
          if (lost_final > cfg.lost_limit) begin
            st_next.status = ST_LINE_LOST;
          end else if (item.elapsed_time > cfg.travel_limit) begin
            st_next.status = ST_TRAVEL_DONE;
          end
        end
      end
    end
  end

endmodule

### sv/line_follower_step.sv
// Three-sensor line follower step. Each input transaction is either a start
// action or one sensor sample with the elapsed time; each one yields exactly
// one result transaction carrying both motor command bytes (bit 7 direction),
// the run status and the latest nonzero sensor pattern. The block takes one
// transaction per clock cycle while the result side does not stall. An
// accepted transaction waits in the input register, where a single pass of the
// steering logic, whose path is set by one 8x8 multiply feeding an add, a clamp
// and a subtract, forms the next run state, and the run state
// itself is the result register. A stall on the result side holds the input
// register and then the input side; a new transaction is still accepted while
// a finished result waits, as long as the input register is free or moving on.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data, and must only be written while no transaction is in flight.
module line_follower_step
  import lfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [2:0]  sensor_bits,
  input  logic [23:0] elapsed_time,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  motor_one_cmd,
  output logic [7:0]  motor_two_cmd,
  output logic [2:0]  run_status,
  output logic [2:0]  last_seen_pattern
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  item_t  in_q;
  logic   in_q_valid;
  logic   advance;
  logic   accept_in;
  logic   process;

  // The result register may be refilled when it is empty or being taken.
  assign advance   = ~out_valid | ~out_stall;
  assign process   = in_q_valid & advance;
  assign in_stall  = in_q_valid & ~advance;
  assign accept_in = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        REG_GAIN_NEAR:        cfg.gain_near        <= cfg_data[7:0];
        REG_GAIN_FAR:         cfg.gain_far         <= cfg_data[7:0];
        REG_GAIN_INTEGRAL:    cfg.gain_integral    <= cfg_data[7:0];
        REG_LOST_LIMIT:       cfg.lost_limit       <= cfg_data[9:0];
        REG_JUNCTION_HOLDOFF: cfg.junction_holdoff <= cfg_data[15:0];
        REG_TRAVEL_LIMIT:     cfg.travel_limit     <= cfg_data[23:0];
        REG_REVERSE_MODE:     cfg.reverse_mode     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register: payload carries no reset.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_q.action       <= action;
      in_q.sensor_bits  <= sensor_bits;
      in_q.elapsed_time <= elapsed_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept_in) begin
      in_q_valid <= 1'b1;
    end else if (process) begin
      in_q_valid <= 1'b0;
    end
  end

  lfs_step_logic u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_q),
    .st_next (st_next)
  );

  // The run state doubles as the result register: it only moves when a
  // transaction is processed, which is exactly when a new result is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (process) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign motor_one_cmd     = st.motor_one;
  assign motor_two_cmd     = st.motor_two;
  assign run_status        = st.status;
  assign last_seen_pattern = st.latest_nonzero;

endmodule

### sv/lfs_checker.sv
module lfs_checker
  import lfs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] motor_one_cmd,
  input logic [7:0] motor_two_cmd,
  input logic [2:0] run_status,
  input logic [2:0] last_seen_pattern
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(motor_one_cmd) &&
      $stable(motor_two_cmd) && $stable(run_status) && $stable(last_seen_pattern))
    else $error("stalled result changed");

  // The input side only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A junction stop leaves both motors stopped until the next start.
  a_junction_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_status == ST_JUNCTION |->
      motor_one_cmd == GO_STOP_ONE && motor_two_cmd == GO_STOP_TWO)
    else $error("junction stop with motors running");

  // Before the first start nothing has been seen and the motors rest.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_status == ST_IDLE |->
      last_seen_pattern == PAT_NONE && motor_one_cmd == GO_STOP_ONE &&
      motor_two_cmd == GO_STOP_TWO)
    else $error("idle result with activity");

endmodule

bind line_follower_step lfs_checker u_lfs_checker (.*);
